/* sv/vsl_pkg.sv */
// Shared types and constants for the vertex shade lighting block.
// No dependencies; used by vsl_div, vsl_dpath, vsl_ctrl and the top level.
`default_nettype none

package vsl_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ADDER    = 3'd0;
    localparam logic [2:0] REG_DIVIDER  = 3'd1;
    localparam logic [2:0] REG_DIR_X    = 3'd2;
    localparam logic [2:0] REG_DIR_Y    = 3'd3;
    localparam logic [2:0] REG_DIR_Z    = 3'd4;
    localparam logic [2:0] REG_BAKED_EN = 3'd5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Item command codes
    localparam logic CMD_LOAD_COL = 1'b0;
    localparam logic CMD_VERTEX   = 1'b1;

    // Column select that stores nothing
    localparam logic [1:0] SEL_NONE = 2'd3;

    localparam logic [12:0] SHADE_MAX   = 13'h1FFF;
    localparam int unsigned LIGHT_SHIFT = 16;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    // One input word as captured by the datapath
    typedef struct packed {
        logic               cmd;
        logic [1:0]         column_sel;
        logic signed [31:0] matrix_a;
        logic signed [31:0] matrix_b;
        logic signed [31:0] matrix_c;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] baked_light;
    } t_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic shade_en;
        logic div_start;
        logic vl_wr_zero;
        logic vl_wr_quo;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_vertex;
        logic sel_ok;
        logic div_zero;
        logic out_free;
        logic div_busy;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

/* sv/vsl_item_if.sv */
// Input channel of the vertex shade lighting block: valid/ready plus item payload.
// No dependencies.
`default_nettype none

interface vsl_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [1:0]         column_sel;
    logic signed [31:0] matrix_a;
    logic signed [31:0] matrix_b;
    logic signed [31:0] matrix_c;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] baked_light;

    modport source (
        output valid, cmd, column_sel, matrix_a, matrix_b, matrix_c,
               normal_x, normal_y, normal_z, baked_light,
        input  ready
    );
    modport sink (
        input  valid, cmd, column_sel, matrix_a, matrix_b, matrix_c,
               normal_x, normal_y, normal_z, baked_light,
        output ready
    );
endinterface

`default_nettype wire

/* sv/vsl_shade_if.sv */
// Output channel of the vertex shade lighting block: valid/ready plus shade.
// No dependencies.
`default_nettype none

interface vsl_shade_if;
    logic        valid;
    logic        ready;
    logic [12:0] shade;

    modport source (output valid, shade, input ready);
    modport sink   (input valid, shade, output ready);
endinterface

`default_nettype wire

/* sv/vsl_div.sv */
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on vsl_pkg.
`default_nettype none

module vsl_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [vsl_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [31:0]                    r_rem;
    logic [31:0]                    r_quo;
    logic [31:0]                    r_den;
    logic                           r_neg;

    logic [31:0] abs_num;
    logic [31:0] abs_den;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;
    logic        last;

    // Magnitudes; -2^31 maps to 2^31, which fits unsigned
    assign abs_num = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign abs_den = i_divisor[31]  ? (32'd0 - i_divisor)  : i_divisor;

    // One restoring step
    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign last   = (r_cnt == vsl_pkg::DIV_CNT_W'(vsl_pkg::DIV_STEPS - 1));

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= abs_num;
            r_den <= abs_den;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    // Sign fix; the -2^31 / -1 case wraps naturally
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

`default_nettype wire

/* sv/vsl_dpath.sv */
// Datapath: configuration registers, view-light store, shared multipliers,
// shade sum and clamp, output register. Depends on vsl_pkg and vsl_div.
`default_nettype none

module vsl_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire vsl_pkg::t_ctrl_cmd                i_ctl,
    output vsl_pkg::t_dp_sts                       o_sts,
    input  wire logic                              i_cfg_we,
    input  wire logic [vsl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [vsl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire vsl_pkg::t_item                    i_item,
    output logic                                   o_shade_valid,
    output logic [12:0]                            o_shade,
    input  wire logic                              i_shade_ready
);

    // Configuration registers
    logic signed [31:0] r_adder;
    logic signed [31:0] r_divider;
    logic signed [31:0] r_dir_x;
    logic signed [31:0] r_dir_y;
    logic signed [31:0] r_dir_z;
    logic               r_baked_en;

    vsl_pkg::t_item     r_item;
    logic signed [31:0] r_vl [3];
    logic [31:0]        r_prod [3];
    logic               r_out_valid;
    logic [12:0]        r_shade;

    logic [31:0] op_a [3];
    logic [31:0] op_b [3];
    logic [31:0] dot;
    logic [15:0] sum16;
    logic [12:0] n_shade;
    logic        div_busy;
    logic        div_done;
    logic [31:0] quotient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adder    <= '0;
            r_divider  <= '0;
            r_dir_x    <= '0;
            r_dir_y    <= '0;
            r_dir_z    <= '0;
            r_baked_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vsl_pkg::REG_ADDER:    r_adder    <= i_cfg_data;
                vsl_pkg::REG_DIVIDER:  r_divider  <= i_cfg_data;
                vsl_pkg::REG_DIR_X:    r_dir_x    <= i_cfg_data;
                vsl_pkg::REG_DIR_Y:    r_dir_y    <= i_cfg_data;
                vsl_pkg::REG_DIR_Z:    r_dir_z    <= i_cfg_data;
                vsl_pkg::REG_BAKED_EN: r_baked_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Captured input word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_item <= i_item;
        end
    end

    // Multiplier operands: normal x view light, or column x light direction
    always_comb begin
        if (r_item.cmd == vsl_pkg::CMD_VERTEX) begin
            op_a[0] = {{16{r_item.normal_x[15]}}, r_item.normal_x};
            op_a[1] = {{16{r_item.normal_y[15]}}, r_item.normal_y};
            op_a[2] = {{16{r_item.normal_z[15]}}, r_item.normal_z};
            op_b[0] = r_vl[0];
            op_b[1] = r_vl[1];
            op_b[2] = r_vl[2];
        end else begin
            op_a[0] = r_item.matrix_a;
            op_a[1] = r_item.matrix_b;
            op_a[2] = r_item.matrix_c;
            op_b[0] = r_dir_x;
            op_b[1] = r_dir_y;
            op_b[2] = r_dir_z;
        end
    end

    // Low 32 bits of each product are all that either path needs
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= op_a[i] * op_b[i];
            end
        end
    end

    assign dot = r_prod[0] + r_prod[1] + r_prod[2];

    // Shade sum, low 16 bits only; dot[31:16] is the floor shift by 16
    always_comb begin
        if (r_baked_en) begin
            sum16 = r_adder[15:0] + r_item.baked_light;
        end else if (r_divider == '0) begin
            sum16 = r_adder[15:0];
        end else begin
            sum16 = r_adder[15:0] + dot[31:vsl_pkg::LIGHT_SHIFT];
        end
        if (sum16[15]) begin
            n_shade = '0;
        end else if (sum16[14:13] != 2'b00) begin
            n_shade = vsl_pkg::SHADE_MAX;
        end else begin
            n_shade = sum16[12:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.shade_en) begin
            r_out_valid <= 1'b1;
        end else if (i_shade_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shade_en) begin
            r_shade <= n_shade;
        end
    end

    vsl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (dot),
        .i_divisor  (r_divider),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // View-light store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_vl[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (r_item.column_sel == 2'(i)) begin
                    if (i_ctl.vl_wr_zero) begin
                        r_vl[i] <= '0;
                    end else if (i_ctl.vl_wr_quo) begin
                        r_vl[i] <= quotient;
                    end
                end
            end
        end
    end

    assign o_sts.is_vertex = (r_item.cmd == vsl_pkg::CMD_VERTEX);
    assign o_sts.sel_ok    = (r_item.column_sel != vsl_pkg::SEL_NONE);
    assign o_sts.div_zero  = (r_divider == '0);
    assign o_sts.out_free  = !r_out_valid || i_shade_ready;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.div_done  = div_done;

    assign o_shade_valid = r_out_valid;
    assign o_shade       = r_shade;

endmodule

`default_nettype wire

/* sv/vsl_ctrl.sv */
// Controller state machine: sequences capture, multiply, shade or divide.
// Depends on vsl_pkg.
`default_nettype none

module vsl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire vsl_pkg::t_dp_sts   i_sts,
    output vsl_pkg::t_ctrl_cmd      o_ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_ctl.mul_en = 1'b1;
                n_state      = ST_POST;
            end
            ST_POST: begin
                // Vertex waits for the output register; column picks its path
                if (i_sts.is_vertex) begin
                    if (i_sts.out_free) begin
                        o_ctl.shade_en = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else if (!i_sts.sel_ok) begin
                    n_state = ST_IDLE;
                end else if (i_sts.div_zero) begin
                    o_ctl.vl_wr_zero = 1'b1;
                    n_state          = ST_IDLE;
                end else begin
                    o_ctl.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_ctl.vl_wr_quo = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

/* sv/vertex_shade_lighting_top.sv */
// Top level of the vertex shade lighting block: controller, datapath, ports.
// Depends on vsl_pkg, vsl_item_if, vsl_shade_if, vsl_ctrl, vsl_dpath.
`default_nettype none

// One word at a time. A vertex word holds the input side through capture,
// three shared 32x32 multipliers, and sum and clamp, and its shade enters
// the output register at the end of the sum stage. If that register
// still holds an earlier shade that the result side has not taken, the vertex
// waits at the sum stage until the register frees up. A column load holds the
// input side through capture and multiply, then through the 32-step radix-2
// divider that forms the view-light component. Loads with a zero divider or
// column select 3 skip the divider. A new word is accepted as soon as the
// previous one is done, even while its shade still waits in the output
// register. Configuration writes are registered and must be made while idle.
module vertex_shade_lighting_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [vsl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [vsl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    vsl_item_if.sink                               i_item,
    vsl_shade_if.source                            o_result
);

    vsl_pkg::t_ctrl_cmd ctl;
    vsl_pkg::t_dp_sts   sts;
    vsl_pkg::t_item     item;
    logic               in_ready;

    // Pack the input payload
    assign item.cmd         = i_item.cmd;
    assign item.column_sel  = i_item.column_sel;
    assign item.matrix_a    = i_item.matrix_a;
    assign item.matrix_b    = i_item.matrix_b;
    assign item.matrix_c    = i_item.matrix_c;
    assign item.normal_x    = i_item.normal_x;
    assign item.normal_y    = i_item.normal_y;
    assign item.normal_z    = i_item.normal_z;
    assign item.baked_light = i_item.baked_light;

    assign i_item.ready = in_ready;

    vsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    vsl_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_item        (item),
        .o_shade_valid (o_result.valid),
        .o_shade       (o_result.shade),
        .i_shade_ready (o_result.ready)
    );

`ifndef SYNTHESIS
    // A shade is only written when the output register has room
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.shade_en |-> sts.out_free)
        else $error("shade written over a pending result");

    // Quotient is stored only when the divider has just finished
    a_quo_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.vl_wr_quo |-> sts.div_done)
        else $error("view light written without divider completion");

    // A started division is running on the next cycle
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.div_start |=> sts.div_busy)
        else $error("divider did not start");

    // One word in flight: no acceptance right after an acceptance
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && in_ready) |=> !in_ready)
        else $error("second word accepted while busy");
`endif

endmodule

`default_nettype wire
